// ----- hdl/sqts_pkg.sv -----
`timescale 1ns / 1ps
// Package for the stepper quarter-turn sequencer: item types, register file,
// sequencer state, mode codes and the coil phase table. No dependencies.
package sqts_pkg;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_SETTLE = 2'd2;

  localparam logic       KIND_TICK = 1'b0;
  localparam logic       KIND_MOVE = 1'b1;

  localparam logic [1:0] REG_QUARTER_STEPS = 2'd0;
  localparam logic [1:0] REG_HALF_STEPS    = 2'd1;
  localparam logic [1:0] REG_START_DELAY   = 2'd2;
  localparam logic [1:0] REG_SETTLE        = 2'd3;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0]  QUARTER_STEPS_RST = 8'd50;
  localparam logic [7:0]  HALF_STEPS_RST    = 8'd100;
  localparam logic [5:0]  START_DELAY_RST   = 6'd20;
  localparam logic [15:0] SETTLE_RST        = 16'd1500;

  localparam logic [7:0] RAMP_STEPS = 8'd5;
  localparam logic [6:0] RAMP_FLOOR = 7'd10;
  localparam logic [6:0] RAMP_DELTA = 7'd2;
  localparam logic [6:0] DELAY_MAX  = 7'd63;

  typedef struct packed {
    logic       kind;
    logic [2:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic [5:0] coil_pattern;
    logic       busy_res;
    logic [2:0] position;
    logic       command_ignored;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  quarter_turn_steps;
    logic [7:0]  half_turn_steps;
    logic [5:0]  start_delay_ms;
    logic [15:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  quadrant;
    logic [1:0]  phase_index;
    logic [1:0]  mode;
    logic        turn_clockwise;
    logic [7:0]  steps_total;
    logic [7:0]  step_index;
    logic [5:0]  step_delay;
    logic [15:0] dwell_count;
  } seq_state_t;

  function automatic logic [5:0] coil_of(input logic [1:0] phase);
    logic [5:0] pat;
    case (phase)
      2'd0: pat = 6'h30;
      2'd1: pat = 6'h06;
      2'd2: pat = 6'h28;
      2'd3: pat = 6'h05;
      default: pat = 6'h30;
    endcase
    return pat;
  endfunction

endpackage

// ----- hdl/sqts_core.sv -----
`timescale 1ns / 1ps
// Next-state and result logic of the sequencer for one item.
// Depends on sqts_pkg.
module sqts_core
  import sqts_pkg::*;
(
  input  seq_state_t st,
  input  cfg_t       cfg,
  input  in_item_t   item,
  output seq_state_t st_next,
  output out_item_t  result
);

  logic [6:0] d_fall;
  logic [6:0] d_rise;
  logic [5:0] d_new;
  logic [7:0] steps_left;
  logic [7:0] idx_inc;
  logic [2:0] tgt_m1;
  logic [1:0] diff;
  logic [7:0] move_steps;
  logic       move_cw;
  logic       move_turns;
  logic [15:0] dwell_dec;
  logic        ignored;

  always_comb begin
    steps_left = st.steps_total - st.step_index;
    idx_inc    = st.step_index + 8'd1;
    d_fall     = {1'b0, st.step_delay};
    if (st.step_index < RAMP_STEPS && d_fall >= RAMP_FLOOR) begin
      d_fall = d_fall - RAMP_DELTA;
    end
    d_rise = d_fall;
    if (steps_left <= RAMP_STEPS && d_fall <= {1'b0, cfg.start_delay_ms}) begin
      d_rise = d_fall + RAMP_DELTA;
    end
    d_new = (d_rise > DELAY_MAX) ? DELAY_MAX[5:0] : d_rise[5:0];

    tgt_m1 = item.target_position - 3'd1;
    diff   = tgt_m1[1:0] - st.quadrant;
    move_turns = 1'b1;
    move_cw    = 1'b1;
    move_steps = cfg.quarter_turn_steps;
    case (diff)
      2'd1: begin
        move_steps = cfg.quarter_turn_steps;
        move_cw    = 1'b1;
      end
      2'd3: begin
        move_steps = cfg.quarter_turn_steps;
        move_cw    = 1'b0;
      end
      2'd2: begin
        move_steps = cfg.half_turn_steps;
        move_cw    = 1'b1;
      end
      default: begin
        move_turns = 1'b0;
      end
    endcase

    dwell_dec = (st.dwell_count != 16'd0) ? st.dwell_count - 16'd1 : st.dwell_count;
    ignored   = 1'b0;
    st_next   = st;

    if (item.kind == KIND_MOVE) begin
      if (st.mode != MODE_IDLE) begin
        ignored = 1'b1;
      end else begin
        if (item.target_position >= 3'd1 && item.target_position <= 3'd4) begin
          st_next.quadrant = tgt_m1[1:0];
        end
        if (item.target_position >= 3'd1 && item.target_position <= 3'd4 &&
            move_turns && move_steps != 8'd0) begin
          st_next.steps_total    = move_steps;
          st_next.step_index     = 8'd0;
          st_next.step_delay     = cfg.start_delay_ms;
          st_next.turn_clockwise = move_cw;
          st_next.phase_index    = move_cw ? st.phase_index + 2'd1 : st.phase_index - 2'd1;
          st_next.dwell_count    = (cfg.start_delay_ms == 6'd0) ? 16'd1
                                   : {10'd0, cfg.start_delay_ms};
          st_next.mode           = MODE_STEP;
        end else begin
          if (item.target_position >= 3'd1 && item.target_position <= 3'd4 && move_turns) begin
            st_next.steps_total    = move_steps;
            st_next.step_index     = 8'd0;
            st_next.step_delay     = cfg.start_delay_ms;
            st_next.turn_clockwise = move_cw;
          end
          st_next.mode        = (cfg.settle_ms == 16'd0) ? MODE_IDLE : MODE_SETTLE;
          st_next.dwell_count = cfg.settle_ms;
        end
      end
    end else begin
      case (st.mode)
        MODE_STEP: begin
          st_next.dwell_count = dwell_dec;
          if (dwell_dec == 16'd0) begin
            st_next.step_delay = d_new;
            st_next.step_index = idx_inc;
            if (idx_inc >= st.steps_total) begin
              st_next.mode        = (cfg.settle_ms == 16'd0) ? MODE_IDLE : MODE_SETTLE;
              st_next.dwell_count = cfg.settle_ms;
            end else begin
              st_next.phase_index = st.turn_clockwise ? st.phase_index + 2'd1
                                                      : st.phase_index - 2'd1;
              st_next.dwell_count = (d_new == 6'd0) ? 16'd1 : {10'd0, d_new};
            end
          end
        end
        MODE_SETTLE: begin
          st_next.dwell_count = dwell_dec;
          if (dwell_dec == 16'd0) begin
            st_next.mode = MODE_IDLE;
          end
        end
        default: begin
          st_next.mode = MODE_IDLE;
        end
      endcase
    end

    result.coil_pattern    = coil_of(st_next.phase_index);
    result.busy_res        = (st_next.mode != MODE_IDLE);
    result.position        = {1'b0, st_next.quadrant} + 3'd1;
    result.command_ignored = ignored;
  end

endmodule

// ----- hdl/stepper_quarter_turn_sequencer.sv -----
`timescale 1ns / 1ps
// Top level of the stepper quarter-turn sequencer: handshakes, register file,
// sequencer state and result register. Depends on sqts_pkg and sqts_core.
//
// Each accepted item (a millisecond tick or a move command) yields exactly one
// registered result item, holding the coil pattern, busy flag, position (quadrant
// plus one) and an ignored-command flag. An item is accepted in every cycle unless
// the result register is full and stalled; the whole state update is one short
// pass of logic from the sequencer registers to the result register.
// Registers may be written at any time the block is idle and take effect on
// the next item.
module stepper_quarter_turn_sequencer
  import sqts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  seq_state_t st;
  seq_state_t st_next;
  out_item_t  result;
  logic       accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  sqts_core u_core (
    .st      (st),
    .cfg     (cfg),
    .item    (in_item),
    .st_next (st_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quarter_turn_steps <= QUARTER_STEPS_RST;
      cfg.half_turn_steps    <= HALF_STEPS_RST;
      cfg.start_delay_ms     <= START_DELAY_RST;
      cfg.settle_ms          <= SETTLE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_QUARTER_STEPS: cfg.quarter_turn_steps <= cfg_data[7:0];
        REG_HALF_STEPS:    cfg.half_turn_steps    <= cfg_data[7:0];
        REG_START_DELAY:   cfg.start_delay_ms     <= cfg_data[5:0];
        REG_SETTLE:        cfg.settle_ms          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.quadrant       <= 2'd0;
      st.phase_index    <= 2'd0;
      st.mode           <= MODE_IDLE;
      st.turn_clockwise <= 1'b1;
      st.steps_total    <= 8'd0;
      st.step_index     <= 8'd0;
      st.step_delay     <= 6'd0;
      st.dwell_count    <= 16'd0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

endmodule
